>>> hw/rtl/frr_pkg.sv
`default_nettype none
package frr_pkg;

    localparam int WINDOW = 64;
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int NB_W   = 31;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_STALE  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BEYOND = 2'd2;

    localparam logic KIND_FRAME   = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    typedef struct packed {
        logic restart;
        logic hold;
        logic drop;
        logic release_nb;
    } frr_cmd_t;

    typedef struct packed {
        logic is_restart;
        logic d_zero;
        logic drop;
        logic next_last;
        logic out_full;
    } frr_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/frr_dp.sv
`default_nettype none
module frr_dp
    import frr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              kind,
    input  wire logic [NB_W-1:0]   frame_id,
    input  wire frr_cmd_t          cmd,
    input  wire logic              out_ready,
    output frr_sts_t               sts,
    output logic                   out_valid,
    output logic [NB_W-1:0]        out_nb,
    output logic [STAT_W-1:0]      out_status,
    output logic                   out_last
);

    logic [NB_W-1:0]   expected_reg, expected_next;
    logic [WINDOW-1:0] held_reg, held_next;
    logic              out_valid_reg, out_valid_next;
    logic [NB_W-1:0]   out_nb_reg, out_nb_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;

    logic [NB_W-1:0]  delta;
    logic [IDX_W-1:0] idx;
    logic             in_window;
    logic             is_held;
    logic             stale;

    always_comb
    begin
        delta     = frame_id - expected_reg;
        idx       = delta[IDX_W-1:0];
        stale     = delta[NB_W-1];
        in_window = (delta < NB_W'(WINDOW));
        is_held   = in_window && held_reg[idx];

        sts.is_restart = (kind == KIND_RESTART);
        sts.d_zero     = (delta == '0);
        sts.drop       = stale || !in_window || is_held;
        sts.next_last  = !held_reg[1];
        sts.out_full   = out_valid_reg;
    end

    always_comb
    begin
        expected_next   = expected_reg;
        held_next       = held_reg;
        out_nb_next     = out_nb_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (cmd.restart)
        begin
            expected_next = '0;
            held_next     = '0;
        end
        else if (cmd.hold)
        begin
            held_next[idx] = 1'b1;
        end
        else if (cmd.drop)
        begin
            out_valid_next  = 1'b1;
            out_nb_next     = frame_id;
            out_status_next = (stale || is_held) ? STAT_STALE : STAT_BEYOND;
            out_last_next   = 1'b1;
        end
        else if (cmd.release_nb)
        begin
            out_valid_next  = 1'b1;
            out_nb_next     = expected_reg;
            out_status_next = STAT_OK;
            out_last_next   = !held_reg[1];
            expected_next   = expected_reg + NB_W'(1);
            held_next       = {1'b0, held_reg[WINDOW-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg  <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            expected_reg  <= expected_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_nb_reg     <= out_nb_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_nb     = out_nb_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule
`default_nettype wire

>>> hw/rtl/frr_ctrl.sv
`default_nettype none
module frr_ctrl
    import frr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire logic     out_ready,
    input  wire frr_sts_t sts,
    output frr_cmd_t      cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg, state_next;
    logic   slot_free;
    logic   accept;
    logic   frame_beat;

    always_comb
    begin
        slot_free  = !sts.out_full || out_ready;
        in_ready   = (state_reg == ST_IDLE) && slot_free;
        accept     = in_valid && in_ready;
        frame_beat = accept && !sts.is_restart;

        cmd.restart    = accept && sts.is_restart;
        cmd.hold       = frame_beat && !sts.d_zero && !sts.drop;
        cmd.drop       = frame_beat && !sts.d_zero && sts.drop;
        cmd.release_nb = (frame_beat && sts.d_zero) || ((state_reg == ST_RUN) && slot_free);

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (frame_beat && sts.d_zero && !sts.next_last)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (slot_free && sts.next_last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

>>> hw/rtl/frame_reorder_in_order_release_top.sv
`default_nettype none
// Reorder buffer with in-order release. Frame numbers (s_tdata) arrive in any order and
// leave on the master side strictly ascending, modulo 2^31. A frame up to WINDOW-1 ahead
// of the expected number is held and gives no beat; stale, duplicate and too-far-ahead
// numbers come back as one beat with a drop status; a restart beat (s_tuser = 1) clears
// the held map and expects frame 0. After a held, restart or dropped frame the next input
// can be taken while the output register is free. When the expected frame arrives, it
// and the held frames that follow it leave as a run of n beats, one per cycle unless
// m_tready stalls, through the single output register, tlast on the final one; no input
// is taken until the last beat of the run is loaded.
module frame_reorder_in_order_release_top
    import frr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [30:0] frame_id
    input  wire logic        s_tuser,   // [0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [30:0] frame_nb
    output logic [1:0]       m_tuser,   // [1:0] status
    output logic             m_tlast
);

    frr_cmd_t          cmd;
    frr_sts_t          sts;
    logic [NB_W-1:0]   out_nb;

    frr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    frr_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .kind       (s_tuser),
        .frame_id   (s_tdata[NB_W-1:0]),
        .cmd        (cmd),
        .out_ready  (m_tready),
        .sts        (sts),
        .out_valid  (m_tvalid),
        .out_nb     (out_nb),
        .out_status (m_tuser),
        .out_last   (m_tlast)
    );

    assign m_tdata = {1'b0, out_nb};

    // drops are always single-beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != STAT_OK) |-> m_tlast)
        else $error("drop beat without tlast");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == STAT_OK || m_tuser == STAT_STALE || m_tuser == STAT_BEYOND))
        else $error("illegal status code");

    // at most one of the datapath commands per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.restart, cmd.hold, cmd.drop, cmd.release_nb}))
        else $error("conflicting datapath commands");

endmodule
`default_nettype wire

>>> dv/frr_release_checker.sv
module frr_release_checker
    import frr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    input  wire logic        m_tlast,
    output int               mismatches,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [NB_W-1:0] HALF_SPACE = NB_W'(1) << (NB_W - 1);

    typedef struct packed {
        logic [NB_W-1:0]   nb;
        logic [STAT_W-1:0] status;
        logic              last;
    } frame_out_t;

    frame_out_t        due_releases[$];
    frame_out_t        want;
    logic [NB_W-1:0]   next_nb = '0;
    logic [WINDOW-1:0] held    = '0;

    function automatic frame_out_t frame_out(input logic [NB_W-1:0] nb,
                                             input logic [STAT_W-1:0] status,
                                             input logic last);
        frame_out_t r;
        r.nb     = nb;
        r.status = status;
        r.last   = last;
        return r;
    endfunction

    task automatic sequence_frame(input logic kind, input logic [NB_W-1:0] id);
        logic [NB_W-1:0] delta;
        logic [NB_W-1:0] nb;
        int              run;
        logic            more;
        if (kind == KIND_RESTART)
        begin
            held    = '0;
            next_nb = '0;
        end
        else
        begin
            delta = id - next_nb;
            if (delta == '0)
            begin
                run = 0;
                do
                begin
                    nb      = next_nb;
                    next_nb = next_nb + NB_W'(1);
                    held    = held >> 1;
                    run++;
                    more = held[0] && (run < WINDOW);
                    due_releases.push_back(frame_out(nb, STAT_OK, !more));
                end
                while (more);
            end
            else if (delta >= HALF_SPACE)
            begin
                due_releases.push_back(frame_out(id, STAT_STALE, 1'b1));
            end
            else if (delta >= NB_W'(WINDOW))
            begin
                due_releases.push_back(frame_out(id, STAT_BEYOND, 1'b1));
            end
            else if (held[delta[IDX_W-1:0]])
            begin
                due_releases.push_back(frame_out(id, STAT_STALE, 1'b1));
            end
            else
            begin
                held[delta[IDX_W-1:0]] = 1'b1;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                sequence_frame(s_tuser, s_tdata[NB_W-1:0]);
            end
            if (m_tvalid && m_tready)
            begin
                if (due_releases.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected beat: frame_nb %0d status %0d last %0b",
                                 m_tdata, m_tuser, m_tlast);
                    end
                end
                else
                begin
                    want = due_releases.pop_front();
                    if (m_tdata !== 32'(want.nb) || m_tuser !== want.status ||
                        m_tlast !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("expected nb/status/last %0d/%0d/%0b, got %0d/%0d/%0b",
                                     want.nb, want.status, want.last,
                                     m_tdata, m_tuser, m_tlast);
                        end
                    end
                end
            end
            outstanding <= due_releases.size();
        end
    end

endmodule

>>> dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import frr_pkg::*;

    localparam int RANDOM_ITEMS   = 90;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT     = 4000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = KIND_FRAME;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          mismatches;
    int          outstanding;

    logic [NB_W-1:0] next_id     = '0;
    int              burst_left  = 0;
    int              items_sent  = 0;
    int              idle_cycles = 0;
    bit              rx_hold_req = 1'b0;

    frame_reorder_in_order_release_top u_top (.*);

    frr_release_checker u_checker (.*);

    always #1 clk = ~clk;

    // nothing accepted on either side for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : rx_pattern
        int mode;
        int span;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 40);
            repeat (span)
            begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    task automatic send_beat(input logic kind, input logic [NB_W-1:0] id);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= 32'(id);
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_all_released();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // consecutive block from the cursor, shuffled or newest-first, with some resends
    task automatic send_sequence(input int len, input bit newest_first);
        logic [NB_W-1:0] order[$];
        logic [NB_W-1:0] swap;
        int              j;
        for (int i = 0; i < len; i++)
        begin
            if (newest_first)
            begin
                order.push_back(next_id + NB_W'(len - 1 - i));
            end
            else
            begin
                order.push_back(next_id + NB_W'(i));
            end
        end
        if (!newest_first)
        begin
            for (int i = len - 1; i > 0; i--)
            begin
                j        = $urandom_range(0, i);
                swap     = order[i];
                order[i] = order[j];
                order[j] = swap;
            end
        end
        for (int i = 0; i < len; i++)
        begin
            send_beat(KIND_FRAME, order[i]);
            if (i > 0 && $urandom_range(0, 7) == 0)
            begin
                send_beat(KIND_FRAME, order[$urandom_range(0, i)]);
            end
        end
        next_id = next_id + NB_W'(len);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 5))
            0:
            begin
                send_beat(KIND_RESTART, NB_W'($urandom()));
                next_id = '0;
            end
            1: send_beat(KIND_FRAME, next_id - NB_W'($urandom_range(1, 32'h4000_0000)));
            2: send_beat(KIND_FRAME, next_id + NB_W'(WINDOW)
                                     + NB_W'($urandom_range(0, 32'h3FFF_FFFF - WINDOW)));
            3, 4: send_beat(KIND_FRAME, NB_W'($urandom()));
            default: send_beat(KIND_FRAME, next_id + NB_W'($urandom_range(1, WINDOW - 1)));
        endcase
    endtask

    initial
    begin : stimulus
        bit hold_done;
        bit pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(KIND_FRAME, 31'd0);                 // in order
        send_beat(KIND_FRAME, 31'd0);                 // stale, one behind
        send_beat(KIND_FRAME, 31'd2);                 // held
        send_beat(KIND_FRAME, 31'd2);                 // duplicate of held
        send_beat(KIND_FRAME, 31'd3);
        send_beat(KIND_FRAME, 31'd1);                 // releases 1..3
        send_beat(KIND_FRAME, 31'd4 + NB_W'(WINDOW - 1)); // window edge, held
        send_beat(KIND_FRAME, 31'd4 + NB_W'(WINDOW)); // just beyond window
        send_beat(KIND_FRAME, 31'd4 + 31'h3FFF_FFFF); // farthest beyond
        send_beat(KIND_FRAME, 31'd4 + 31'h4000_0000); // half space: stale
        send_beat(KIND_FRAME, 31'h7FFF_FFFF);
        send_beat(KIND_FRAME, 31'd5);
        send_beat(KIND_RESTART, 31'h7FFF_FFFF);       // held map cleared
        send_beat(KIND_FRAME, 31'd0);
        send_beat(KIND_FRAME, 31'd5);
        send_beat(KIND_FRAME, 31'd1);
        send_beat(KIND_FRAME, 31'd2);
        send_beat(KIND_RESTART, 31'd0);
        send_beat(KIND_FRAME, 31'h5555_5555);
        send_beat(KIND_FRAME, 31'h2AAA_AAAA);
        wait_all_released();

        next_id    = '0;
        items_sent = 0;
        send_sequence(WINDOW, 1'b1);                  // longest release run
        while (items_sent < RANDOM_ITEMS)
        begin
            if (!hold_done && items_sent >= 30)
            begin
                rx_hold_req = 1'b1;
                hold_done   = 1'b1;
            end
            if (!pause_done && items_sent >= 80)
            begin
                wait_all_released();
                pause_done = 1'b1;
            end
            if ($urandom_range(0, 9) < 7)
            begin
                send_sequence(($urandom_range(0, 7) == 0) ? $urandom_range(16, WINDOW)
                                                          : $urandom_range(1, 8), 1'b0);
            end
            else
            begin
                send_noise();
            end
        end

        wait_all_released();
        repeat (2 * WINDOW) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
